// ===== src/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Status and action codes, the slot table entry and the sequencer states.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Default table depth and fixed field widths.
  localparam int NUM_SLOTS_DEF = 16;
  localparam int ID_W          = 4;
  localparam int PID_W         = 5;
  localparam int PRIO_W        = 8;
  localparam int CODE_W        = 32;
  localparam int ACT_W         = 3;
  localparam int KIND_W        = 2;
  localparam int OUTC_W        = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 4;

  localparam logic [PID_W-1:0]     PARENT_NONE = 5'd16;
  localparam logic [PRIO_W-1:0]    MAIN_PRIO   = 8'd10;
  localparam logic [PRIO_W-1:0]    MIN_SLICE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN    = 2'd1;
  localparam logic [ID_W-1:0]      IDLE_RESET  = 4'd1;
  localparam logic [ID_W-1:0]      MAIN_RESET  = 4'd0;

  typedef enum logic [2:0] {
    ST_RUNNING, ST_READY, ST_BLOCKED, ST_WAITING, ST_HANGING, ST_DIED, ST_FREE
  } status_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE, ACT_PREEMPT, ACT_BLOCK, ACT_UNBLOCK, ACT_YIELD, ACT_EXIT, ACT_WAIT
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BLOCKED, KIND_HANGING, KIND_WAITING
  } kind_t;

  typedef enum logic [OUTC_W-1:0] {
    WO_NONE, WO_REAPED, WO_NO_CHILD, WO_PENDING
  } outcome_t;

  // One entry of the slot table.
  typedef struct packed {
    status_t             status;
    logic [PRIO_W-1:0]   prio;
    logic [PID_W-1:0]    parent;
    logic [CODE_W-1:0]   code;
  } slot_t;

  localparam slot_t SLOT_RESET = '{status: ST_FREE, prio: '0, parent: PARENT_NONE, code: '0};

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CR, S_UB, S_DCHK, S_DCUR, S_XRD, S_XEV,
    S_POP, S_NRD, S_NWR, S_WRD, S_WEV, S_DONE
  } fsm_t;

  // A thread in one of these states may be put back on the ready queue.
  function automatic logic wakeable(status_t s);
    return (s == ST_BLOCKED) || (s == ST_HANGING) || (s == ST_WAITING);
  endfunction

endpackage

// ===== src/rrts_if.sv =====
// ----------------------------------------------------------------------------
// rrts_if: request and result channels of the thread scheduler
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rrts_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::ACT_W-1:0]    action;
  logic [rrts_pkg::ID_W-1:0]     thread_id;
  logic [rrts_pkg::PID_W-1:0]    parent_id;
  logic [rrts_pkg::PRIO_W-1:0]   priority_req;
  logic [rrts_pkg::KIND_W-1:0]   block_kind;
  logic signed [rrts_pkg::CODE_W-1:0] exit_code;

  modport source (output valid, action, thread_id, parent_id, priority_req, block_kind,
                  exit_code, input ready);
  modport sink   (input valid, action, thread_id, parent_id, priority_req, block_kind,
                  exit_code, output ready);
endinterface

interface rrts_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::ID_W-1:0]     running_thread;
  logic                          switched;
  logic [rrts_pkg::PRIO_W-1:0]   slice_ticks;
  logic                          error;
  logic [rrts_pkg::OUTC_W-1:0]   wait_outcome;
  logic [rrts_pkg::ID_W-1:0]     child_id;
  logic signed [rrts_pkg::CODE_W-1:0] child_exit_code;

  modport source (output valid, running_thread, switched, slice_ticks, error, wait_outcome,
                  child_id, child_exit_code, input ready);
  modport sink   (input valid, running_thread, switched, slice_ticks, error, wait_outcome,
                  child_id, child_exit_code, output ready);
endinterface

// ===== src/round_robin_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler: hardware thread scheduler with a ready FIFO
// Slot table and ready queue live in synchronous memories; a sequencer
// reads, modifies and writes back one entry at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_chan, one item per scheduler action. Each request
//   gives exactly one result item on out_chan. Registers idle_slot (index 0)
//   and main_slot (index 1) are written through cfg_we/cfg_index/cfg_data;
//   writing main_slot restarts the scheduler with that slot running.
//   One item is worked on at a time; a new item is taken once the previous
//   result sits in the output register.
//   After reset, and after a main_slot write, the S_INIT state writes the main entry
//   before in_chan.ready rises. Entries carry valid flags, so no clearing pass.
//   When the receiver stalls, the result holds in the output register and the
//   sequencer waits with the next result until that register is free.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rrts_in_if.sink                          in_chan,
  rrts_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [rrts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rrts_pkg::*;

  localparam int IW = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(NUM_SLOTS);
  localparam logic [8:0]    NUM_W    = 9'(NUM_SLOTS);

  // Memories.
  slot_t          slot_mem [NUM_SLOTS];
  logic [IW-1:0]  fifo_mem [NUM_SLOTS];
  slot_t          mem_q;
  logic [IW-1:0]  fifo_q;
  logic [IW-1:0]  rd_addr_r;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  slot_t          mem_wdata;
  logic           fifo_we;
  logic [IW-1:0]  fifo_wdata;
  slot_t          rd_e;

  // Control and state registers.
  fsm_t                 state_r, state_nxt;
  logic [ID_W-1:0]      idle_r, idle_nxt, main_r, main_nxt;
  logic [IW-1:0]        cur_r, cur_nxt;
  logic [PRIO_W-1:0]    cur_prio_r, cur_prio_nxt;
  logic [IW-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  status_t              st_r, st_nxt;
  logic                 is_wait_r, is_wait_nxt;
  logic                 child_seen_r, child_seen_nxt;
  logic                 pop_r, pop_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Latched request fields.
  logic [ID_W-1:0]      tid_r;
  logic [PID_W-1:0]     pid_r;
  logic [PRIO_W-1:0]    prio_r;
  logic [CODE_W-1:0]    code_r;

  // Result being built and the output register.
  logic                 res_err_r, res_err_nxt, res_sw_r, res_sw_nxt;
  outcome_t             res_outc_r, res_outc_nxt;
  logic [IW-1:0]        res_child_r, res_child_nxt;
  logic [CODE_W-1:0]    res_code_r, res_code_nxt;
  logic [ID_W-1:0]      o_run_r, o_child_r;
  logic [PRIO_W-1:0]    o_slice_r;
  logic                 o_sw_r, o_err_r;
  logic [OUTC_W-1:0]    o_outc_r;
  logic [CODE_W-1:0]    o_code_r;

  // Index conversions between 4-bit fields and table indexes.
  logic [7:0] in_tid_w, tid_w, idle_w, main_w, cur_w, child_w;
  logic [IW-1:0] in_tid_idx, tid_idx, idle_idx, main_idx;
  assign in_tid_w   = {4'b0, in_chan.thread_id};
  assign tid_w      = {4'b0, tid_r};
  assign idle_w     = {4'b0, idle_r};
  assign main_w     = {4'b0, main_r};
  assign cur_w      = 8'(cur_r);
  assign child_w    = 8'(res_child_r);
  assign in_tid_idx = in_tid_w[IW-1:0];
  assign tid_idx    = tid_w[IW-1:0];
  assign idle_idx   = idle_w[IW-1:0];
  assign main_idx   = main_w[IW-1:0];

  logic in_acc, out_free, cfg_ok, cfg_restart, tid_ok, child_match;
  logic [PRIO_W-1:0] new_prio;
  assign in_acc      = in_chan.valid && in_chan.ready;
  assign out_free    = !out_valid_r || out_chan.ready;
  assign cfg_ok      = cfg_we && ({5'b0, cfg_data} < NUM_W);
  assign cfg_restart = cfg_ok && (cfg_index == CFG_MAIN);
  assign tid_ok      = {5'b0, tid_r} < NUM_W;
  assign rd_e        = valid_r[rd_addr_r] ? mem_q : SLOT_RESET;
  assign child_match = (rd_e.status != ST_FREE) && ({4'b0, rd_e.parent} == 9'(cur_r));
  assign new_prio    = (prio_r < MIN_SLICE) ? MIN_SLICE : prio_r;

  // Slot table and ready queue memories with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    mem_q     <= slot_mem[mem_raddr];
    rd_addr_r <= mem_raddr;
    if (fifo_we) begin
      fifo_mem[tail_r] <= fifo_wdata;
    end
    fifo_q <= fifo_mem[head_r];
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.action)
            ACT_CREATE:  state_nxt = S_CR;
            ACT_UNBLOCK: state_nxt = S_UB;
            ACT_PREEMPT, ACT_YIELD, ACT_EXIT: state_nxt = S_DCHK;
            ACT_BLOCK:   state_nxt = (in_chan.block_kind > KIND_WAITING) ? S_DONE : S_DCHK;
            ACT_WAIT:    state_nxt = S_WRD;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_CR, S_UB: state_nxt = S_DONE;
      S_DCHK: begin
        if ((st_r == ST_RUNNING) ? (count_r < FULL_CNT) :
            ((count_r != '0) ||
             wakeable((idle_idx == cur_r) ? st_r : rd_e.status))) begin
          state_nxt = S_DCUR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DCUR: state_nxt = (st_r == ST_DIED) ? S_XRD : S_POP;
      S_XRD:  state_nxt = S_XEV;
      S_XEV:  state_nxt = (idx_r == LAST_IDX) ? S_POP : S_XRD;
      S_POP:  state_nxt = S_NRD;
      S_NRD:  state_nxt = S_NWR;
      S_NWR:  state_nxt = S_DONE;
      S_WRD:  state_nxt = S_WEV;
      S_WEV: begin
        if (child_match && (rd_e.status == ST_DIED)) begin
          state_nxt = S_DONE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = (child_seen_r || child_match) ? S_DCHK : S_DONE;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_DONE: state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_INIT;
    endcase
    if (cfg_restart) begin
      state_nxt = S_INIT;
    end
  end

  // Datapath and memory control of each state.
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = rd_e;
    mem_raddr      = '0;
    fifo_we        = 1'b0;
    fifo_wdata     = cur_r;
    idle_nxt       = idle_r;
    main_nxt       = main_r;
    cur_nxt        = cur_r;
    cur_prio_nxt   = cur_prio_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    idx_nxt        = idx_r;
    st_nxt         = st_r;
    is_wait_nxt    = is_wait_r;
    child_seen_nxt = child_seen_r;
    pop_nxt        = pop_r;
    res_err_nxt    = res_err_r;
    res_sw_nxt     = res_sw_r;
    res_outc_nxt   = res_outc_r;
    res_child_nxt  = res_child_r;
    res_code_nxt   = res_code_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;

    case (state_r)
      // Install the main thread as running.
      S_INIT: begin
        mem_we              = 1'b1;
        mem_waddr           = main_idx;
        mem_wdata           = '{status: ST_RUNNING, prio: MAIN_PRIO, parent: PARENT_NONE,
                                code: '0};
        valid_nxt[main_idx] = 1'b1;
        cur_nxt             = main_idx;
        cur_prio_nxt        = MAIN_PRIO;
      end
      // Take a request and start the first table read.
      S_IDLE: begin
        if (in_acc) begin
          res_err_nxt    = 1'b0;
          res_sw_nxt     = 1'b0;
          res_outc_nxt   = WO_NONE;
          res_child_nxt  = '0;
          res_code_nxt   = '0;
          is_wait_nxt    = 1'b0;
          child_seen_nxt = 1'b0;
          idx_nxt        = '0;
          st_nxt         = ST_RUNNING;
          mem_raddr      = idle_idx;
          case (in_chan.action)
            ACT_CREATE, ACT_UNBLOCK: mem_raddr = in_tid_idx;
            ACT_PREEMPT, ACT_YIELD:  st_nxt = ST_RUNNING;
            ACT_BLOCK: begin
              case (in_chan.block_kind)
                KIND_BLOCKED: st_nxt = ST_BLOCKED;
                KIND_HANGING: st_nxt = ST_HANGING;
                KIND_WAITING: st_nxt = ST_WAITING;
                default:      res_err_nxt = 1'b1;
              endcase
            end
            ACT_EXIT: st_nxt = ST_DIED;
            ACT_WAIT: begin
              is_wait_nxt = 1'b1;
              mem_raddr   = '0;
            end
            default: res_err_nxt = 1'b1;
          endcase
        end
      end
      // Create: the slot must be free, the queue not full, the parent legal.
      S_CR: begin
        if (!tid_ok || (rd_e.status != ST_FREE) || (count_r >= FULL_CNT) ||
            ((pid_r != PARENT_NONE) &&
             ((pid_r > 5'd15) || ({4'b0, pid_r} >= NUM_W) || (pid_r == {1'b0, tid_r})))) begin
          res_err_nxt = 1'b1;
        end else begin
          mem_we             = 1'b1;
          mem_waddr          = tid_idx;
          mem_wdata          = '{status: ST_READY, prio: new_prio, parent: pid_r, code: '0};
          valid_nxt[tid_idx] = 1'b1;
          fifo_we            = 1'b1;
          fifo_wdata         = tid_idx;
          tail_nxt           = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_nxt          = count_r + 1'b1;
        end
      end
      // Unblock: a sleeping slot goes back to the queue tail.
      S_UB: begin
        if (!tid_ok || !wakeable(rd_e.status) || (count_r >= FULL_CNT)) begin
          res_err_nxt = 1'b1;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = tid_idx;
          mem_wdata.status = ST_READY;
          fifo_we          = 1'b1;
          fifo_wdata       = tid_idx;
          tail_nxt         = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_nxt        = count_r + 1'b1;
        end
      end
      // Decision check with the idle entry in hand; then read the current entry.
      S_DCHK: begin
        mem_raddr = cur_r;
        if (!((st_r == ST_RUNNING) ? (count_r < FULL_CNT) :
              ((count_r != '0) ||
               wakeable((idle_idx == cur_r) ? st_r : rd_e.status)))) begin
          res_err_nxt = 1'b1;
        end
      end
      // Retire the current thread; a running one is queued unless the queue is empty.
      S_DCUR: begin
        mem_we           = 1'b1;
        mem_waddr        = cur_r;
        mem_wdata.status = (st_r == ST_RUNNING) ? ST_READY : st_r;
        if (st_r == ST_DIED) begin
          mem_wdata.code = code_r;
        end
        pop_nxt   = (count_r != '0);
        idx_nxt   = '0;
        mem_raddr = '0;
        if ((st_r == ST_RUNNING) && (count_r != '0)) begin
          fifo_we   = 1'b1;
          tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      // Reparent sweep after an exit.
      S_XRD: mem_raddr = idx_r;
      S_XEV: begin
        if ({4'b0, rd_e.parent} == 9'(cur_r)) begin
          mem_we           = 1'b1;
          mem_waddr        = idx_r;
          mem_wdata.parent = {1'b0, idle_r};
        end
        idx_nxt = idx_r + 1'b1;
      end
      // Pop the queue head.
      S_POP: begin
        if (pop_r) begin
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      // Choose the next thread and read its entry.
      S_NRD: begin
        if (pop_r) begin
          cur_nxt = fifo_q;
        end else if (st_r == ST_RUNNING) begin
          cur_nxt = cur_r;
        end else begin
          cur_nxt = idle_idx;
        end
        mem_raddr = cur_nxt;
      end
      // Mark the next thread running and reload its slice.
      S_NWR: begin
        mem_we           = 1'b1;
        mem_waddr        = cur_r;
        mem_wdata.status = ST_RUNNING;
        cur_prio_nxt     = rd_e.prio;
        res_sw_nxt       = 1'b1;
        if (is_wait_r) begin
          res_outc_nxt = WO_PENDING;
        end
      end
      // Child scan for wait.
      S_WRD: mem_raddr = idx_r;
      S_WEV: begin
        mem_raddr = idle_idx;
        if (child_match) begin
          child_seen_nxt = 1'b1;
        end
        if (child_match && (rd_e.status == ST_DIED)) begin
          valid_nxt[idx_r] = 1'b0;
          res_outc_nxt     = WO_REAPED;
          res_child_nxt    = idx_r;
          res_code_nxt     = rd_e.code;
        end else if (idx_r == LAST_IDX) begin
          if (!(child_seen_r || child_match)) begin
            res_outc_nxt = WO_NO_CHILD;
          end
          st_nxt = ST_RUNNING;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // Hand the result to the output register.
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // Register writes; a main slot write restarts the scheduler.
    if (cfg_ok) begin
      if (cfg_index == CFG_IDLE) begin
        idle_nxt = cfg_data;
      end else if (cfg_index == CFG_MAIN) begin
        main_nxt  = cfg_data;
        valid_nxt = '0;
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idle_r      <= IDLE_RESET;
      main_r      <= MAIN_RESET;
      cur_r       <= '0;
      cur_prio_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idle_r      <= idle_nxt;
      main_r      <= main_nxt;
      cur_r       <= cur_nxt;
      cur_prio_r  <= cur_prio_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    st_r         <= st_nxt;
    is_wait_r    <= is_wait_nxt;
    child_seen_r <= child_seen_nxt;
    pop_r        <= pop_nxt;
    res_err_r    <= res_err_nxt;
    res_sw_r     <= res_sw_nxt;
    res_outc_r   <= res_outc_nxt;
    res_child_r  <= res_child_nxt;
    res_code_r   <= res_code_nxt;
    if (in_acc) begin
      tid_r  <= in_chan.thread_id;
      pid_r  <= in_chan.parent_id;
      prio_r <= in_chan.priority_req;
      code_r <= in_chan.exit_code;
    end
    if ((state_r == S_DONE) && out_free) begin
      o_run_r   <= cur_w[ID_W-1:0];
      o_sw_r    <= res_sw_r && !res_err_r;
      o_slice_r <= cur_prio_r;
      o_err_r   <= res_err_r;
      o_outc_r  <= res_err_r ? WO_NONE : res_outc_r;
      o_child_r <= res_err_r ? '0 : child_w[ID_W-1:0];
      o_code_r  <= res_err_r ? '0 : res_code_r;
    end
  end

  // Channel outputs.
  assign in_chan.ready            = (state_r == S_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.running_thread  = o_run_r;
  assign out_chan.switched        = o_sw_r;
  assign out_chan.slice_ticks     = o_slice_r;
  assign out_chan.error           = o_err_r;
  assign out_chan.wait_outcome    = o_outc_r;
  assign out_chan.child_id        = o_child_r;
  assign out_chan.child_exit_code = o_code_r;

  // Assertions.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("ready count above table depth");
  a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> valid_r[cur_r]) else $error("current slot entry not valid");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we && !fifo_we) else $error("table write while idle");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_we |=> (state_r != S_IDLE)) else $error("item accepted without work");

endmodule

// ===== test/tb_round_robin_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler: self-checking bench of the thread scheduler
// A directed table of requests runs first, then random request sequences.
// Results are checked against a software copy of the slot table and queue, or against a typed-in value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_round_robin_thread_scheduler;
  import rrts_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rrts_in_if  req_ch ();
  rrts_out_if res_ch ();

  round_robin_thread_scheduler dut (
    .clk(clk), .rst_n(rst_n), .in_chan(req_ch), .out_chan(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Request and result item layouts.
  typedef struct {
    logic [2:0]  action;
    logic [3:0]  tid;
    logic [4:0]  pid;
    logic [7:0]  prio;
    logic [1:0]  kind;
    logic [31:0] code;
  } req_t;

  typedef struct {
    logic [3:0]  running;
    logic        sw;
    logic [7:0]  slice;
    logic        err;
    logic [1:0]  outcome;
    logic [3:0]  child;
    logic [31:0] ccode;
  } res_t;

  // Shadow scheduler state.
  status_t     sh_status [NSLOT];
  logic [7:0]  sh_prio   [NSLOT];
  logic [4:0]  sh_parent [NSLOT];
  logic [31:0] sh_code   [NSLOT];
  logic [3:0]  sh_fifo   [NSLOT];
  int          sh_head, sh_tail, sh_count;
  logic [3:0]  sh_cur, sh_idle, sh_main;

  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   out_stall_max = 0;

  function automatic void sched_restart();
    for (int i = 0; i < NSLOT; i++) begin
      sh_status[i] = ST_FREE;
      sh_prio[i] = '0;
      sh_parent[i] = PARENT_NONE;
      sh_code[i] = '0;
    end
    sh_head = 0;
    sh_tail = 0;
    sh_count = 0;
    sh_cur = sh_main;
    sh_status[sh_main] = ST_RUNNING;
    sh_prio[sh_main] = MAIN_PRIO;
  endfunction

  function automatic logic bool_wake(status_t s);
    return s == ST_BLOCKED || s == ST_HANGING || s == ST_WAITING;
  endfunction

  function automatic void fifo_push(logic [3:0] s);
    sh_fifo[sh_tail] = s;
    sh_tail = (sh_tail + 1) % NSLOT;
    sh_count++;
  endfunction

  // Can a scheduling decision be made once the current slot has status cs?
  function automatic logic can_decide(status_t cs);
    status_t ist;
    if (cs == ST_RUNNING) return sh_count < NSLOT;
    if (sh_count != 0) return 1'b1;
    ist = (sh_idle == sh_cur) ? cs : sh_status[sh_idle];
    return bool_wake(ist);
  endfunction

  function automatic void run_next();
    logic [3:0] nxt;
    if (sh_status[sh_cur] == ST_RUNNING) begin
      sh_status[sh_cur] = ST_READY;
      fifo_push(sh_cur);
    end
    if (sh_count == 0) begin
      sh_status[sh_idle] = ST_READY;
      fifo_push(sh_idle);
    end
    nxt = sh_fifo[sh_head];
    sh_head = (sh_head + 1) % NSLOT;
    sh_count--;
    sh_status[nxt] = ST_RUNNING;
    sh_cur = nxt;
  endfunction

  // Applies one request to the shadow state and returns its result item.
  function automatic res_t schedule_step(req_t r);
    res_t o;
    status_t st;
    logic child_seen;
    int found;
    o = '{default: '0};
    case (r.action)
      ACT_CREATE: begin
        if (sh_status[r.tid] != ST_FREE || sh_count >= NSLOT ||
            (r.pid != PARENT_NONE && (r.pid > 15 || r.pid[3:0] == r.tid))) begin
          o.err = 1'b1;
        end else begin
          sh_status[r.tid] = ST_READY;
          sh_prio[r.tid] = (r.prio < MIN_SLICE) ? MIN_SLICE : r.prio;
          sh_parent[r.tid] = r.pid;
          sh_code[r.tid] = '0;
          fifo_push(r.tid);
        end
      end
      ACT_PREEMPT: begin
        if (!can_decide(sh_status[sh_cur])) o.err = 1'b1;
        else begin
          run_next();
          o.sw = 1'b1;
        end
      end
      ACT_BLOCK: begin
        if (r.kind > KIND_WAITING) o.err = 1'b1;
        else begin
          st = (r.kind == KIND_BLOCKED) ? ST_BLOCKED :
               (r.kind == KIND_HANGING) ? ST_HANGING : ST_WAITING;
          if (!can_decide(st)) o.err = 1'b1;
          else begin
            sh_status[sh_cur] = st;
            run_next();
            o.sw = 1'b1;
          end
        end
      end
      ACT_UNBLOCK: begin
        if (!bool_wake(sh_status[r.tid]) || sh_count >= NSLOT) o.err = 1'b1;
        else begin
          sh_status[r.tid] = ST_READY;
          fifo_push(r.tid);
        end
      end
      ACT_YIELD: begin
        if (sh_status[sh_cur] != ST_RUNNING || !can_decide(ST_RUNNING)) o.err = 1'b1;
        else begin
          run_next();
          o.sw = 1'b1;
        end
      end
      ACT_EXIT: begin
        if (!can_decide(ST_DIED)) o.err = 1'b1;
        else begin
          sh_status[sh_cur] = ST_DIED;
          sh_code[sh_cur] = r.code;
          for (int i = 0; i < NSLOT; i++)
            if (sh_parent[i] == {1'b0, sh_cur}) sh_parent[i] = {1'b0, sh_idle};
          run_next();
          o.sw = 1'b1;
        end
      end
      ACT_WAIT: begin
        child_seen = 1'b0;
        found = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (found < 0 && sh_status[i] != ST_FREE && sh_parent[i] == {1'b0, sh_cur}) begin
            child_seen = 1'b1;
            if (sh_status[i] == ST_DIED) found = i;
          end
        end
        if (found >= 0) begin
          o.outcome = WO_REAPED;
          o.child = found[3:0];
          o.ccode = sh_code[found];
          sh_status[found] = ST_FREE;
          sh_prio[found] = '0;
          sh_parent[found] = PARENT_NONE;
        end else if (!child_seen) begin
          o.outcome = WO_NO_CHILD;
        end else if (sh_status[sh_cur] != ST_RUNNING || !can_decide(ST_RUNNING)) begin
          o.err = 1'b1;
        end else begin
          run_next();
          o.sw = 1'b1;
          o.outcome = WO_PENDING;
        end
      end
      default: o.err = 1'b1;
    endcase
    o.running = sh_cur;
    o.slice = sh_prio[sh_cur];
    return o;
  endfunction

  // Random gap: mostly short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_round_robin_thread_scheduler: done, errors");
      $finish;
    end
  end

  // Result receiver with random stalls.
  int rx_gap = 0;
  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (res_ch.running_thread !== e.running) begin
          $error("running_thread: expected %0d, actual %0d", e.running, res_ch.running_thread);
          errors++;
        end
        if (res_ch.switched !== e.sw) begin
          $error("switched: expected %0d, actual %0d", e.sw, res_ch.switched);
          errors++;
        end
        if (res_ch.slice_ticks !== e.slice) begin
          $error("slice_ticks: expected %0d, actual %0d", e.slice, res_ch.slice_ticks);
          errors++;
        end
        if (res_ch.error !== e.err) begin
          $error("error: expected %0d, actual %0d", e.err, res_ch.error);
          errors++;
        end
        if (res_ch.wait_outcome !== e.outcome) begin
          $error("wait_outcome: expected %0d, actual %0d", e.outcome, res_ch.wait_outcome);
          errors++;
        end
        if (res_ch.child_id !== e.child) begin
          $error("child_id: expected %0d, actual %0d", e.child, res_ch.child_id);
          errors++;
        end
        if (res_ch.child_exit_code !== e.ccode) begin
          $error("child_exit_code: expected %0h, actual %0h", e.ccode, res_ch.child_exit_code);
          errors++;
        end
      end
    end
    if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      res_ch.ready <= 1'b0;
    end else begin
      rx_gap <= (out_stall_max == 0) ? 0 : pick_gap();
      res_ch.ready <= 1'b1;
    end
  end

  // Sends one request item and records its expected result.
  // Valid stays high after an accept when the next item follows at once.
  task automatic send_req(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.thread_id <= r.tid;
    req_ch.parent_id <= r.pid;
    req_ch.priority_req <= r.prio;
    req_ch.block_kind <= r.kind;
    req_ch.exit_code <= r.code;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(schedule_step(r));
  endtask

  // Waits for all results and the sequencer to go quiet.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * NSLOT + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDLE) sh_idle = val;
    else if (idx == CFG_MAIN) begin
      sh_main = val;
      sched_restart();
    end
    repeat (4) @(posedge clk);
  endtask

  // Builds a random request, biased toward legal useful actions.
  function automatic req_t rand_req();
    req_t r;
    int p;
    r.code = $urandom();
    r.prio = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom());
    r.kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    r.tid = 4'($urandom());
    p = $urandom_range(9);
    if (p < 4) r.pid = {1'b0, sh_cur};
    else if (p < 6) r.pid = PARENT_NONE;
    else r.pid = 5'($urandom());
    p = $urandom_range(99);
    if (p < 20) r.action = ACT_CREATE;
    else if (p < 32) r.action = ACT_PREEMPT;
    else if (p < 44) r.action = ACT_BLOCK;
    else if (p < 58) r.action = ACT_UNBLOCK;
    else if (p < 66) r.action = ACT_YIELD;
    else if (p < 80) r.action = ACT_EXIT;
    else if (p < 97) r.action = ACT_WAIT;
    else r.action = 3'd7;
    return r;
  endfunction

  // Directed table: action, tid, pid, prio, kind, code, expectation known?
  typedef struct {
    req_t r;
    logic known;
    res_t e;
  } row_t;

  row_t dir_rows[$];

  function automatic row_t mk(logic [2:0] a, logic [3:0] t, logic [4:0] pd, logic [7:0] pr,
                              logic [1:0] k, logic [31:0] c);
    row_t w;
    w.r = '{action: a, tid: t, pid: pd, prio: pr, kind: k, code: c};
    w.known = 1'b0;
    w.e = '{default: '0};
    return w;
  endfunction

  initial begin
    row_t w;
    req_ch.valid = 1'b0;
    req_ch.action = '0;
    req_ch.thread_id = '0;
    req_ch.parent_id = '0;
    req_ch.priority_req = '0;
    req_ch.block_kind = '0;
    req_ch.exit_code = '0;
    sh_idle = IDLE_RESET;
    sh_main = MAIN_RESET;
    sched_restart();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Wait right after reset: no child, main keeps running at priority ten.
    w = mk(ACT_WAIT, 0, 0, 0, 0, 0);
    w.known = 1'b1;
    w.e = '{running: 4'd0, sw: 1'b0, slice: 8'd10, err: 1'b0, outcome: WO_NO_CHILD,
            child: 4'd0, ccode: 32'd0};
    dir_rows.push_back(w);
    // Unknown action seven is rejected.
    w = mk(3'd7, 0, 0, 0, 0, 0);
    w.known = 1'b1;
    w.e = '{running: 4'd0, sw: 1'b0, slice: 8'd10, err: 1'b1, outcome: WO_NONE,
            child: 4'd0, ccode: 32'd0};
    dir_rows.push_back(w);
    // Block kind three is rejected.
    w = mk(ACT_BLOCK, 0, 0, 0, 3, 0);
    w.known = 1'b1;
    w.e = '{running: 4'd0, sw: 1'b0, slice: 8'd10, err: 1'b1, outcome: WO_NONE,
            child: 4'd0, ccode: 32'd0};
    dir_rows.push_back(w);
    // Block with an empty queue and a free idle slot is rejected.
    dir_rows.push_back(mk(ACT_BLOCK, 0, 0, 0, 0, 0));
    // Unblock of a free slot, create with bad parents, create on an occupied slot.
    dir_rows.push_back(mk(ACT_UNBLOCK, 5, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_CREATE, 3, 3, 5, 0, 0));
    dir_rows.push_back(mk(ACT_CREATE, 3, 31, 5, 0, 0));
    dir_rows.push_back(mk(ACT_CREATE, 0, 16, 5, 0, 0));
    // Legal creates: priority zero becomes one, maximum priority.
    dir_rows.push_back(mk(ACT_CREATE, 1, 16, 0, 0, 0));
    dir_rows.push_back(mk(ACT_CREATE, 15, 0, 255, 0, 0));
    dir_rows.push_back(mk(ACT_CREATE, 2, 0, 7, 0, 0));
    dir_rows.push_back(mk(ACT_PREEMPT, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_YIELD, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_BLOCK, 0, 0, 0, 1, 0));
    dir_rows.push_back(mk(ACT_BLOCK, 0, 0, 0, 2, 0));
    dir_rows.push_back(mk(ACT_UNBLOCK, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_UNBLOCK, 15, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_WAIT, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_EXIT, 0, 0, 0, 0, 32'h8000_0000));
    dir_rows.push_back(mk(ACT_EXIT, 0, 0, 0, 0, 32'h7fff_ffff));
    dir_rows.push_back(mk(ACT_EXIT, 0, 0, 0, 0, 32'hffff_ffff));
    dir_rows.push_back(mk(ACT_WAIT, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_WAIT, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_WAIT, 0, 0, 0, 0, 0));

    // Walk the directed table; rows with a typed-in result expect that value.
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].r);
      if (dir_rows[i].known) begin
        void'(expected_results.pop_back());
        expected_results.push_back(dir_rows[i].e);
      end
    end
    drain();

    // Random phases, each under a new register setting.
    out_stall_max = 1;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_IDLE, 4'd15); write_reg(CFG_MAIN, 4'd0); end
        1: begin write_reg(CFG_IDLE, 4'd0); write_reg(CFG_MAIN, 4'd15); end
        2: begin write_reg(CFG_IDLE, 4'd5); write_reg(CFG_MAIN, 4'd5); end
        3: begin write_reg(2'd2, 4'd9); write_reg(2'd3, 4'd3); write_reg(CFG_MAIN, 4'd1); end
        default: begin
          write_reg(CFG_IDLE, 4'($urandom()));
          write_reg(CFG_MAIN, 4'($urandom()));
        end
      endcase
      // Warm up with the idle thread, then mixed traffic.
      send_req('{action: ACT_CREATE, tid: sh_idle, pid: PARENT_NONE, prio: 8'd3,
                 kind: 2'd0, code: 32'd0});
      for (int n = 0; n < 190; n++) send_req(rand_req());
      drain();
    end

    if (errors == 0) begin
      $display("tb_round_robin_thread_scheduler: done, clean");
    end else begin
      $display("tb_round_robin_thread_scheduler: done, errors");
    end
    $finish;
  end

endmodule
